// ----- hw/rtl/ccksb_pkg.sv -----
// shared types and constants for the clipped color-key sprite blit
// no dependencies; used by every module of the block
`default_nettype none

package ccksb_pkg;

    localparam int CNT_W       = 10;   // sprite column/row counters and clip edges
    localparam int POS_W       = 11;   // signed destination origin
    localparam int COLOR_W     = 16;
    localparam int ADDR_W      = 19;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X      = 8'd0,
        REG_DEST_Y      = 8'd1,
        REG_CLIP_LEFT   = 8'd2,
        REG_CLIP_TOP    = 8'd3,
        REG_CLIP_RIGHT  = 8'd4,
        REG_CLIP_BOTTOM = 8'd5,
        REG_KEY_COLOR   = 8'd6,
        REG_KEY_ENABLE  = 8'd7
    } t_reg_idx;

    // classified pixel handed from the front to the back
    typedef struct packed {
        logic               write_enable;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pix_item;

endpackage

`default_nettype wire

// ----- hw/rtl/ccksb_front.sv -----
// front end: configuration registers, sprite counters, clip and key test
// depends on ccksb_pkg
`default_nettype none

module ccksb_front #(
    parameter int SCREEN_WIDTH    = 640,
    parameter int SCREEN_HEIGHT   = 480,
    parameter int PIXEL_BITS      = 16,
    parameter int MAX_SPRITE_SIZE = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [ccksb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ccksb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ccksb_pkg::COLOR_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output ccksb_pkg::t_pix_item                   o_item
);
    import ccksb_pkg::*;

    localparam logic [CNT_W-1:0] RIGHT_MAX  = CNT_W'(SCREEN_WIDTH - 1);
    localparam logic [CNT_W-1:0] BOTTOM_MAX = CNT_W'(SCREEN_HEIGHT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_SPRITE_SIZE - 1);
    localparam bit               NARROW_KEY = (PIXEL_BITS < 16);

    logic signed [POS_W-1:0] r_dest_x, r_dest_y;
    logic [CNT_W-1:0]        r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;
    logic [COLOR_W-1:0]      r_key_color;
    logic                    r_key_enable;
    logic [CNT_W-1:0]        r_col, r_row, n_col, n_row;

    logic signed [POS_W:0]   scr_x, scr_y;
    logic [CNT_W-1:0]        right_lim, bottom_lim;
    logic                    in_window, keyed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x      <= '0;
            r_dest_y      <= '0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= CNT_W'(639);
            r_clip_bottom <= CNT_W'(479);
            r_key_color   <= '0;
            r_key_enable  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEST_X:      r_dest_x      <= i_cfg_data[POS_W-1:0];
                REG_DEST_Y:      r_dest_y      <= i_cfg_data[POS_W-1:0];
                REG_CLIP_LEFT:   r_clip_left   <= i_cfg_data[CNT_W-1:0];
                REG_CLIP_TOP:    r_clip_top    <= i_cfg_data[CNT_W-1:0];
                REG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data[CNT_W-1:0];
                REG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data[CNT_W-1:0];
                REG_KEY_COLOR:   r_key_color   <= i_cfg_data;
                REG_KEY_ENABLE:  r_key_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // screen position and window test
    always_comb begin
        scr_x      = (POS_W+1)'(r_dest_x) + $signed({2'b00, r_col});
        scr_y      = (POS_W+1)'(r_dest_y) + $signed({2'b00, r_row});
        right_lim  = (r_clip_right  > RIGHT_MAX)  ? RIGHT_MAX  : r_clip_right;
        bottom_lim = (r_clip_bottom > BOTTOM_MAX) ? BOTTOM_MAX : r_clip_bottom;
        in_window = (scr_x >= $signed({2'b00, r_clip_left}))
                 && (scr_x <= $signed({2'b00, right_lim}))
                 && (scr_y >= $signed({2'b00, r_clip_top}))
                 && (scr_y <= $signed({2'b00, bottom_lim}));
        if (NARROW_KEY) begin
            keyed = r_key_enable && (s_axis_tdata[7:0] == r_key_color[7:0]);
        end else begin
            keyed = r_key_enable && (s_axis_tdata == r_key_color);
        end
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    always_comb begin
        o_item.write_enable = in_window && !keyed;
        o_item.col          = scr_x[CNT_W-1:0];
        o_item.row          = scr_y[CNT_W-1:0];
        o_item.color        = s_axis_tdata;
        o_item.last         = s_axis_tlast;
    end

    // counters: end of sprite wins over end of line, both saturate
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            priority if (s_axis_tlast) begin
                n_col = '0;
                n_row = '0;
            end else if (s_axis_tuser) begin
                n_col = '0;
                n_row = (r_row >= CNT_MAX) ? CNT_MAX : r_row + 1'b1;
            end else begin
                n_col = (r_col >= CNT_MAX) ? CNT_MAX : r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ccksb_fifo.sv -----
// two-entry queue of classified pixels between front and back
// depends on ccksb_pkg
`default_nettype none

module ccksb_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire ccksb_pkg::t_pix_item  i_item,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output ccksb_pkg::t_pix_item       o_item,
    output logic                       o_empty
);
    import ccksb_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_pix_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]      r_count;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ccksb_back.sv -----
// back end: linear address multiply and registered output stage
// depends on ccksb_pkg
`default_nettype none

module ccksb_back #(
    parameter int SCREEN_WIDTH = 640
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire ccksb_pkg::t_pix_item          i_item,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [39:0]                        m_axis_tdata,  // pixel_address, pixel_value
    output logic                               m_axis_tuser,  // write_enable
    output logic                               m_axis_tlast
);
    import ccksb_pkg::*;

    localparam logic [ADDR_W-1:0] SW = ADDR_W'(SCREEN_WIDTH);

    logic                r_valid, n_valid;
    logic                r_we;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [COLOR_W-1:0]  r_value;
    logic                r_last;

    assign o_pop   = !i_empty && (!r_valid || m_axis_tready);
    assign n_valid = o_pop || (r_valid && !m_axis_tready);
    // address wraps to the output width
    assign n_addr  = ADDR_W'(i_item.row) * SW + ADDR_W'(i_item.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we    <= i_item.write_enable;
            r_addr  <= i_item.write_enable ? n_addr : '0;
            r_value <= i_item.write_enable ? i_item.color : '0;
            r_last  <= i_item.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'b0, r_value, r_addr};
    assign m_axis_tuser  = r_we;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// ----- hw/rtl/clipped_color_key_sprite_blit.sv -----
// path: an accepted pixel is written into the queue, then into the output register that presents it
// throughput: one pixel per cycle while the sink does not stall, set by the front test and the back address multiply
// the two-entry queue lets the sink stall without stopping the source at once
// reset: synchronous active low; counters clear, registers load the viewport defaults
// top level of the clipped color-key sprite blit; depends on ccksb_pkg,
// ccksb_front, ccksb_fifo and ccksb_back
`default_nettype none

module clipped_color_key_sprite_blit #(
    parameter int SCREEN_WIDTH    = 640,
    parameter int SCREEN_HEIGHT   = 480,
    parameter int PIXEL_BITS      = 16,
    parameter int MAX_SPRITE_SIZE = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ccksb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ccksb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sprite pixel stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [15:0]                       s_axis_tdata,  // color
    input  wire logic                              s_axis_tuser,  // end_of_line
    input  wire logic                              s_axis_tlast,  // end_of_sprite
    // framebuffer write stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [39:0]                            m_axis_tdata,  // pixel_address, pixel_value
    output logic                                   m_axis_tuser,  // write_enable
    output logic                                   m_axis_tlast   // last
);
    import ccksb_pkg::*;

    // classified pixel path front -> queue -> back
    t_pix_item push_item, pop_item;
    logic      push, pop, full, empty;

    // registers are always writable; writes must arrive only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    ccksb_front #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .PIXEL_BITS      (PIXEL_BITS),
        .MAX_SPRITE_SIZE (MAX_SPRITE_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (full),
        .o_push        (push),
        .o_item        (push_item)
    );

    // short queue so either side may stall on its own
    ccksb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty)
    );

    // address generation and output register
    ccksb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (pop_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for clipped_color_key_sprite_blit: random sprite streams under many
// viewport setups, each framebuffer write checked against an in-bench pixel predictor
// depends on ccksb_pkg and the clipped_color_key_sprite_blit rtl only
`timescale 1ns / 1ps

module testbench;

    import ccksb_pkg::*;

    localparam int SCREEN_W      = 640;
    localparam int SCREEN_H      = 480;
    localparam int PIXEL_BITS    = 16;
    localparam int SPRITE_MAX    = 1024;
    localparam int RANDOM_PIXELS = 500;
    localparam int PHASE_PIXELS  = 40;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int MAX_PRINTED   = 40;
    localparam int NUM_PRESETS   = 7;
    localparam int QUIET_PHASE   = 7;

    // indexes outside the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_FIRST_UNUSED = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_LAST         = 8'hFF;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               eol;
        logic               eos;
    } t_src_pixel;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    typedef struct {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] value;
        logic               last;
    } t_fb_write;

    // dut ports; the ones the bench drives are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // color
    logic                  s_axis_tuser = 1'b0; // end_of_line
    logic                  s_axis_tlast = 1'b0; // end_of_sprite
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;        // pixel_address, pixel_value
    logic                  m_axis_tuser;        // write_enable
    logic                  m_axis_tlast;        // last

    // stimulus queues and their outstanding counts
    t_src_pixel pixel_stream[$];
    t_reg_write reg_writes[$];
    t_fb_write  fb_writes_due[$];
    int         pixels_unsent = 0;
    int         regs_unsent = 0;
    int         mismatches = 0;
    bit         quiet = 1'b0;   // set to turn off idling on both sides

    // predictor copy of the viewport registers, at their reset values
    int                 view_dest_x = 0;
    int                 view_dest_y = 0;
    logic [CNT_W-1:0]   view_clip_left = '0;
    logic [CNT_W-1:0]   view_clip_top = '0;
    logic [CNT_W-1:0]   view_clip_right = 10'd639;
    logic [CNT_W-1:0]   view_clip_bottom = 10'd479;
    logic [COLOR_W-1:0] view_key_color = '0;
    logic               view_key_on = 1'b1;

    // predictor copy of the sprite position counters
    logic [CNT_W-1:0] col_count = '0;
    logic [CNT_W-1:0] row_count = '0;

    clipped_color_key_sprite_blit #(
        .SCREEN_WIDTH   (SCREEN_W),
        .SCREEN_HEIGHT  (SCREEN_H),
        .PIXEL_BITS     (PIXEL_BITS),
        .MAX_SPRITE_SIZE(SPRITE_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // generous bound on the whole run
    initial begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // a break on either side with a chance of 7 in 100 per call, none while quiet
    function automatic bit take_break();
        return !quiet && ($urandom_range(99) < 7);
    endfunction

    function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] c);
        return (c >= CNT_W'(SPRITE_MAX - 1)) ? CNT_W'(SPRITE_MAX - 1) : c + 1'b1;
    endfunction

    // clip test, keying and address for one accepted pixel, then counter update
    task automatic blit_pixel(input logic [COLOR_W-1:0] color, input logic eol,
                              input logic eos);
        int        sx;
        int        sy;
        int        right;
        int        bottom;
        bit        in_window;
        bit        keyed;
        t_fb_write w;
        sx     = view_dest_x + int'(col_count);
        sy     = view_dest_y + int'(row_count);
        // window edges past the screen are pulled back onto it
        right  = (int'(view_clip_right) > SCREEN_W - 1) ? SCREEN_W - 1 : int'(view_clip_right);
        bottom = (int'(view_clip_bottom) > SCREEN_H - 1) ? SCREEN_H - 1 : int'(view_clip_bottom);
        in_window = sx >= int'(view_clip_left) && sx <= right &&
                    sy >= int'(view_clip_top) && sy <= bottom;
        if (PIXEL_BITS < 16)
            keyed = view_key_on && color[7:0] == view_key_color[7:0];
        else
            keyed = view_key_on && color == view_key_color;
        w.we    = in_window && !keyed;
        w.addr  = w.we ? ADDR_W'(sy * SCREEN_W + sx) : '0;
        w.value = w.we ? color : '0;
        w.last  = eos;
        fb_writes_due.push_back(w);
        // end of sprite wins over end of line
        if (eos) begin
            col_count = '0;
            row_count = '0;
        end else if (eol) begin
            col_count = '0;
            row_count = step_count(row_count);
        end else begin
            col_count = step_count(col_count);
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_DEST_X:      view_dest_x = $signed(data[POS_W-1:0]);
            REG_DEST_Y:      view_dest_y = $signed(data[POS_W-1:0]);
            REG_CLIP_LEFT:   view_clip_left = data[CNT_W-1:0];
            REG_CLIP_TOP:    view_clip_top = data[CNT_W-1:0];
            REG_CLIP_RIGHT:  view_clip_right = data[CNT_W-1:0];
            REG_CLIP_BOTTOM: view_clip_bottom = data[CNT_W-1:0];
            REG_KEY_COLOR:   view_key_color = data[COLOR_W-1:0];
            REG_KEY_ENABLE:  view_key_on = data[0];
            default: ;
        endcase
    endtask

    // configuration driver: one write per transaction, predictor updated on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                regs_unsent--;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_writes.size() != 0 && !take_break()) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= reg_writes[0].index;
                    i_cfg_data  <= reg_writes[0].data;
                    void'(reg_writes.pop_front());
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // pixel driver: prediction happens at the edge where the pixel is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                blit_pixel(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                pixels_unsent--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_stream.size() != 0 && !take_break()) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_stream[0].color;
                    s_axis_tuser  <= pixel_stream[0].eol;
                    s_axis_tlast  <= pixel_stream[0].eos;
                    void'(pixel_stream.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // write monitor: each accepted transaction against the oldest predicted write
    always @(posedge i_clk) begin : fb_watch
        t_fb_write want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (fb_writes_due.size() == 0) begin
                    note_mismatch("framebuffer write with none predicted");
                end else begin
                    want = fb_writes_due.pop_front();
                    if (m_axis_tuser !== want.we)
                        note_mismatch($sformatf("write_enable %b, predicted %b",
                                                m_axis_tuser, want.we));
                    if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
                        note_mismatch($sformatf("pixel_address %0d, predicted %0d",
                                                m_axis_tdata[ADDR_W-1:0], want.addr));
                    if (m_axis_tdata[ADDR_W +: COLOR_W] !== want.value)
                        note_mismatch($sformatf("pixel_value %h, predicted %h",
                                                m_axis_tdata[ADDR_W +: COLOR_W], want.value));
                    if (m_axis_tlast !== want.last)
                        note_mismatch($sformatf("last %b, predicted %b",
                                                m_axis_tlast, want.last));
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    task automatic push_pixel(input logic [COLOR_W-1:0] color, input logic eol,
                              input logic eos);
        pixel_stream.push_back('{color, eol, eos});
        pixels_unsent++;
    endtask

    task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] index,
                                   input logic [CFG_DATA_W-1:0] data);
        reg_writes.push_back('{index, data});
        regs_unsent++;
    endtask

    task automatic flush_reg_writes();
        while (regs_unsent != 0)
            @(posedge i_clk);
    endtask

    // all pixels taken, then every predicted write seen (bounded)
    task automatic wait_for_drain();
        int spins;
        spins = 0;
        while (pixels_unsent != 0)
            @(posedge i_clk);
        while (fb_writes_due.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        if (fb_writes_due.size() != 0) begin
            note_mismatch($sformatf("%0d predicted writes never arrived",
                                    fb_writes_due.size()));
            fb_writes_due.delete();
        end
    endtask

    // writes all eight registers; unused upper data bits carry random filler
    task automatic load_setup(input int dx, input int dy, input int cl, input int ct,
                              input int cr, input int cb, input int key, input bit key_on);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom); d[POS_W-1:0] = dx[POS_W-1:0];
        queue_reg_write(REG_DEST_X, d);
        d = CFG_DATA_W'($urandom); d[POS_W-1:0] = dy[POS_W-1:0];
        queue_reg_write(REG_DEST_Y, d);
        d = CFG_DATA_W'($urandom); d[CNT_W-1:0] = cl[CNT_W-1:0];
        queue_reg_write(REG_CLIP_LEFT, d);
        d = CFG_DATA_W'($urandom); d[CNT_W-1:0] = ct[CNT_W-1:0];
        queue_reg_write(REG_CLIP_TOP, d);
        d = CFG_DATA_W'($urandom); d[CNT_W-1:0] = cr[CNT_W-1:0];
        queue_reg_write(REG_CLIP_RIGHT, d);
        d = CFG_DATA_W'($urandom); d[CNT_W-1:0] = cb[CNT_W-1:0];
        queue_reg_write(REG_CLIP_BOTTOM, d);
        queue_reg_write(REG_KEY_COLOR, key[COLOR_W-1:0]);
        d = CFG_DATA_W'($urandom); d[0] = key_on;
        queue_reg_write(REG_KEY_ENABLE, d);
        // now and then a stray write outside the map
        if ($urandom_range(3) == 0)
            queue_reg_write(CFG_IDX_W'($urandom_range(REG_INDEX_FIRST_UNUSED, REG_INDEX_LAST)),
                            CFG_DATA_W'($urandom));
        flush_reg_writes();
    endtask

    // setup aimed mostly at a window that sprites actually overlap
    task automatic random_setup();
        int dx;
        int dy;
        int cl;
        int ct;
        int cr;
        int cb;
        dx = ($urandom_range(9) == 0) ? $urandom : $urandom_range(720) - 60;
        dy = ($urandom_range(9) == 0) ? $urandom : $urandom_range(540) - 40;
        if ($urandom_range(5) == 0) begin
            cl = $urandom; ct = $urandom; cr = $urandom; cb = $urandom;
        end else begin
            cl = $urandom_range(200); cr = $urandom_range(1023, 300);
            ct = $urandom_range(150); cb = $urandom_range(1023, 200);
        end
        load_setup(dx, dy, cl, ct, cr, cb, $urandom_range(16'hFFFF), $urandom_range(1));
    endtask

    // key color often, near misses and the color extremes sometimes
    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(9))
            0, 1:    return view_key_color;
            2:       return view_key_color ^ (COLOR_W'(1) << $urandom_range(COLOR_W - 1));
            3:       return '0;
            4:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // a sprite in row order; a broken one carries line and sprite marks at random
    task automatic push_sprite(input int w, input int h, input bit broken);
        bit at_end;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                at_end = (r == h - 1) && (c == w - 1);
                if (broken)
                    push_pixel(pick_color(), $urandom_range(5) == 0,
                               ($urandom_range(24) == 0) || (at_end && $urandom_range(1)));
                else
                    push_pixel(pick_color(), (c == w - 1) && !(at_end && $urandom_range(3) == 0),
                               at_end);
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        int phase;
        int random_pixels;
        int phase_pixels;
        int w;
        int h;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset viewport: key color zero with keying on
        push_pixel(16'h0000, 1'b0, 1'b0);   // key color, dropped
        push_pixel(16'hFFFF, 1'b0, 1'b0);
        push_pixel(16'h0100, 1'b0, 1'b0);   // low byte matches the key, upper does not
        push_pixel(16'h8001, 1'b1, 1'b0);   // end of line
        push_pixel(16'h1234, 1'b0, 1'b0);
        push_pixel(16'h0000, 1'b0, 1'b0);
        push_pixel(16'hABCD, 1'b1, 1'b1);   // both marks, sprite end wins
        push_pixel(16'h5555, 1'b0, 1'b0);
        push_pixel(16'hAAAA, 1'b0, 1'b1);   // sprite end mid-row
        wait_for_drain();

        // writes outside the register map change nothing
        queue_reg_write(REG_INDEX_FIRST_UNUSED, 16'h03F0);
        queue_reg_write(REG_INDEX_LAST, 16'hFFFF);
        flush_reg_writes();
        push_pixel(16'h0000, 1'b0, 1'b0);
        push_pixel(16'h7E7E, 1'b1, 1'b1);
        wait_for_drain();

        // oversized sprite, run with no idling: a row past the column limit
        quiet = 1'b1;
        load_setup(-400, 0, 0, 0, 639, 479, 0, 1'b0);
        for (int i = 0; i < SPRITE_MAX + 6; i++)
            push_pixel(COLOR_W'($urandom), i == SPRITE_MAX + 5, i == SPRITE_MAX + 5);
        wait_for_drain();
        quiet = 1'b0;

        // random sprites, first under the extreme setups, then random ones
        phase = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            case (phase)
                // far negative origin, all clipped
                0: load_setup(-1024, -1024, 0, 0, 1023, 1023, 0, 1'b0);
                // window and origin past the screen
                1: load_setup(1023, 1023, 1023, 1023, 1023, 1023, 16'hFFFF, 1'b1);
                // window edges beyond the screen, pulled back to 639 and 479
                2: load_setup(620, 465, 600, 450, 1023, 1023, 16'hFFFF, 1'b1);
                // negative origin, plain copy
                3: load_setup(-12, -6, 0, 0, 639, 479, 0, 1'b0);
                // inverted columns
                4: load_setup(100, 100, 300, 50, 200, 400, $urandom_range(16'hFFFF), 1'b1);
                // inverted rows
                5: load_setup(100, 100, 50, 300, 400, 200, $urandom_range(16'hFFFF), 1'b1);
                // single-pixel window
                6: load_setup(3, 2, 5, 4, 5, 4, $urandom_range(16'hFFFF), $urandom_range(1));
                default: random_setup();
            endcase
            quiet = (phase == QUIET_PHASE);
            phase_pixels = 0;
            while (phase_pixels < PHASE_PIXELS) begin
                if ($urandom_range(7) == 0) begin
                    w = $urandom_range(4, 1);
                    h = $urandom_range(12, 1);
                end else begin
                    w = $urandom_range(16, 1);
                    h = $urandom_range(4, 1);
                end
                push_sprite(w, h, $urandom_range(99) < 15);
                phase_pixels += w * h;
                // sender holds off until the block has emptied
                if ($urandom_range(9) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
            random_pixels += phase_pixels;
            phase++;
        end
        quiet = 1'b0;

        // after the drain, wait on so that any stray write is caught
        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
